>>> rtl/bde_pkg.sv
// Shared types and constants for the BRIEF descriptor extraction core.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bde_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;
    localparam int TIDX_IN_W  = 8;
    localparam int OFF_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int WORD_W     = 64;
    localparam int WORD_IDX_W = 2;
    localparam int OUT_WORDS  = 4;
    localparam int DESC_W     = WORD_W * OUT_WORDS;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 72;
    localparam int SAMP_W     = 9;
    localparam int WINDOW_SIZE = 32;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_KEYPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_TEST,
        CMD_KEYPT
    } cmd_kind_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] by;
        logic signed [OFF_W-1:0] bx;
        logic signed [OFF_W-1:0] ay;
        logic signed [OFF_W-1:0] ax;
    } test_pair_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [PIX_W-1:0]     pixel;
        logic [TIDX_IN_W-1:0] test_index;
        test_pair_t           pair;
        logic                 in_bounds;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TEST,
        BK_OUT
    } bk_state_t;

endpackage

`default_nettype wire

>>> rtl/bde_front.sv
// Front end: accepts input beats, holds the image size registers, drops
// items that have no effect and runs the border check. Depends on bde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bde_front
    import bde_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int TEST_COUNT  = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic [FUNC_W-1:0]    s_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output cmd_t                      push_data
);

    localparam int BORDER = WINDOW_SIZE / 2;

    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [DIM_W-1:0]   w_sat;
    logic [DIM_W-1:0]   h_sat;
    logic               keep;
    logic               ok;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [TIDX_IN_W-1:0] test_index;
    cmd_kind_t          kind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data;
            end
            else
            begin
                image_height_reg <= cfg_data;
            end
        end
    end

    assign pos_x      = s_tdata[7:0];
    assign pos_y      = s_tdata[15:8];
    assign test_index = s_tdata[31:24];

    assign w_sat = (32'(image_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width_reg;
    assign h_sat = (32'(image_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_reg;

    assign ok = (32'(pos_x) > BORDER) && (32'(pos_y) > BORDER)
             && ((10'(pos_x) + 10'(BORDER)) < 10'(w_sat))
             && ((10'(pos_y) + 10'(BORDER)) < 10'(h_sat));

    always_comb
    begin
        keep = 1'b0;
        kind = CMD_KEYPT;
        unique case (s_tuser)
            FUNC_PIXEL:
            begin
                kind = CMD_PIXEL;
                keep = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
            end
            FUNC_TEST:
            begin
                kind = CMD_TEST;
                keep = 32'(test_index) < TEST_COUNT;
            end
            FUNC_KEYPT:
            begin
                kind = CMD_KEYPT;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;

    always_comb
    begin
        push_data.kind       = kind;
        push_data.pos_x      = pos_x;
        push_data.pos_y      = pos_y;
        push_data.pixel      = s_tdata[23:16];
        push_data.test_index = test_index;
        push_data.pair.ax    = s_tdata[36:32];
        push_data.pair.ay    = s_tdata[41:37];
        push_data.pair.bx    = s_tdata[46:42];
        push_data.pair.by    = s_tdata[51:47];
        push_data.in_bounds  = ok;
    end

endmodule

`default_nettype wire

>>> rtl/bde_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on bde_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bde_cmd_fifo
    import bde_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_data
);

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             slot_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = cnt_reg != CNT_W'(CMD_FIFO_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bde_back.sv
// Back end: image and test memories, the test sequencer and the output
// stage that sends each descriptor as four beats. Depends on bde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bde_back
    import bde_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int TEST_COUNT = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire cmd_t                pop_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast,
    output logic                     m_tuser
);

    localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int IDX_W     = $clog2(TEST_COUNT);
    localparam int CNT_W     = $clog2(TEST_COUNT + 1);

    logic [PIX_W-1:0] img_mem [IMG_DEPTH];
    test_pair_t       tbl_mem [TEST_COUNT];

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [CNT_W-1:0]   iss_reg;
    logic [CNT_W-1:0]   iss_next;
    logic [WORD_IDX_W-1:0] wrd_reg;
    logic [WORD_IDX_W-1:0] wrd_next;
    logic [TEST_COUNT-1:0] desc_reg;
    logic [TEST_COUNT-1:0] desc_next;
    logic [POS_W-1:0]   kp_x_reg;
    logic [POS_W-1:0]   kp_x_next;
    logic [POS_W-1:0]   kp_y_reg;
    logic [POS_W-1:0]   kp_y_next;
    logic               ok_reg;
    logic               ok_next;
    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s2_vld_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               iss_active;
    logic               pop_fire;
    logic               img_we;
    logic               tbl_we;
    logic [IMG_AW-1:0]  img_waddr;
    logic [IMG_AW-1:0]  addr_a;
    logic [IMG_AW-1:0]  addr_b;
    logic [SAMP_W-1:0]  samp_ax;
    logic [SAMP_W-1:0]  samp_ay;
    logic [SAMP_W-1:0]  samp_bx;
    logic [SAMP_W-1:0]  samp_by;
    test_pair_t         tbl_q;
    logic [PIX_W-1:0]   pix_a_q;
    logic [PIX_W-1:0]   pix_b_q;
    logic [DESC_W-1:0]  desc_ext;

    assign pop_ready  = state_reg == BK_IDLE;
    assign pop_fire   = pop_valid && pop_ready;
    assign img_we     = pop_fire && (pop_data.kind == CMD_PIXEL);
    assign tbl_we     = pop_fire && (pop_data.kind == CMD_TEST);
    assign iss_active = (state_reg == BK_TEST) && (iss_reg < CNT_W'(TEST_COUNT));

    assign img_waddr = IMG_AW'(IMG_AW'(pop_data.pos_y) * IMG_AW'(MAX_WIDTH)
                     + IMG_AW'(pop_data.pos_x));

    assign samp_ax = {1'b0, kp_x_reg} + {{(SAMP_W-OFF_W){tbl_q.ax[OFF_W-1]}}, tbl_q.ax};
    assign samp_ay = {1'b0, kp_y_reg} + {{(SAMP_W-OFF_W){tbl_q.ay[OFF_W-1]}}, tbl_q.ay};
    assign samp_bx = {1'b0, kp_x_reg} + {{(SAMP_W-OFF_W){tbl_q.bx[OFF_W-1]}}, tbl_q.bx};
    assign samp_by = {1'b0, kp_y_reg} + {{(SAMP_W-OFF_W){tbl_q.by[OFF_W-1]}}, tbl_q.by};

    assign addr_a = IMG_AW'(IMG_AW'(samp_ay) * IMG_AW'(MAX_WIDTH) + IMG_AW'(samp_ax));
    assign addr_b = IMG_AW'(IMG_AW'(samp_by) * IMG_AW'(MAX_WIDTH) + IMG_AW'(samp_bx));

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= pop_data.pixel;
        end
        pix_a_q <= img_mem[addr_a];
        pix_b_q <= img_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[pop_data.test_index[IDX_W-1:0]] <= pop_data.pair;
        end
        tbl_q <= tbl_mem[iss_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= iss_reg[IDX_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        desc_reg   <= desc_next;
        kp_x_reg   <= kp_x_next;
        kp_y_reg   <= kp_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            iss_reg    <= '0;
            wrd_reg    <= '0;
            ok_reg     <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            wrd_reg    <= wrd_next;
            ok_reg     <= ok_next;
            s1_vld_reg <= iss_active;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        wrd_next   = wrd_reg;
        desc_next  = desc_reg;
        kp_x_next  = kp_x_reg;
        kp_y_next  = kp_y_reg;
        ok_next    = ok_reg;

        if (s2_vld_reg)
        begin
            desc_next[s2_idx_reg] = pix_a_q > pix_b_q;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_fire && (pop_data.kind == CMD_KEYPT))
                begin
                    desc_next = '0;
                    kp_x_next = pop_data.pos_x;
                    kp_y_next = pop_data.pos_y;
                    ok_next   = pop_data.in_bounds;
                    iss_next  = '0;
                    wrd_next  = '0;
                    state_next = pop_data.in_bounds ? BK_TEST : BK_OUT;
                end
            end
            BK_TEST:
            begin
                if (iss_active)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                else if (!s1_vld_reg)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (m_tready)
                begin
                    wrd_next = wrd_reg + 1'b1;
                    if (wrd_reg == WORD_IDX_W'(OUT_WORDS - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign desc_ext = DESC_W'(desc_reg);
    assign m_tvalid = state_reg == BK_OUT;
    assign m_tdata  = {{(M_DATA_W-WORD_W-WORD_IDX_W){1'b0}}, wrd_reg,
                       desc_ext[{wrd_reg, 6'b0} +: WORD_W]};
    assign m_tlast  = wrd_reg == WORD_IDX_W'(OUT_WORDS - 1);
    assign m_tuser  = ok_reg;

endmodule

`default_nettype wire

>>> rtl/brief_descriptor_extract_core.sv
// A keypoint inside the border runs all TEST_COUNT tests before its first
// beat; one outside the border goes straight to the output with no tests.
// The tests run at one test per cycle on the dual-read image memory; the back
// end takes a new item only when idle, so load items and keypoints wait while
// a descriptor is tested or sent.
// Reset clears control state and sets both image size registers to 256;
// the image memory and the test table hold nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module brief_descriptor_extract_core
    import bde_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int TEST_COUNT  = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pos_x, pos_y, pixel, test_index, off_x1, off_y1, off_x2, off_y2, zero pad
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // func
    input  wire logic [FUNC_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // desc_word, word_index, zero pad
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tlast,
    // in_bounds
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    bde_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .TEST_COUNT  (TEST_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bde_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bde_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TEST_COUNT (TEST_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
